[hdl/pfr_pkg.sv]
`timescale 1ns / 1ps

package pfr_pkg;

    // Line and framing codes
    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESC_BYTE    = 8'h7D;
    localparam logic [7:0] ESC_XOR     = 8'h20;

    // Register defaults and queue sizing
    localparam logic [15:0] MAX_BODY_RESET = 16'd1500;
    localparam int          QUEUE_DEPTH    = 4;

    // Result kind
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Protocol selector
    localparam logic [1:0] SEL_LCP  = 2'd0;
    localparam logic [1:0] SEL_PAP  = 2'd1;
    localparam logic [1:0] SEL_CHAP = 2'd2;

    // End-of-frame status
    localparam logic [1:0] STAT_FCS_GOOD = 2'd0;
    localparam logic [1:0] STAT_FCS_BAD  = 2'd1;
    localparam logic [1:0] STAT_LEN_ERR  = 2'd2;

    // Register index
    localparam logic REG_MAX_BODY_LEN = 1'b0;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  body_byte;
        logic [1:0]  protocol_sel;
        logic [7:0]  msg_code;
        logic [7:0]  msg_id;
        logic [15:0] body_len;
        logic [1:0]  frame_status;
    } t_result;

    // Handshake between the unescaped byte queue and the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_req;

endpackage

[hdl/pfr_fifo.sv]
`timescale 1ns / 1ps

module pfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pfr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[hdl/pfr_unescape.sv]
`timescale 1ns / 1ps

module pfr_unescape (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_rx_byte,
    input  logic       i_q_full,
    output logic       o_q_push,
    output logic [7:0] o_q_data
);

    logic r_esc_pending, n_esc_pending;
    logic take;

    assign take = i_push && !i_q_full;

    always_comb begin
        n_esc_pending = r_esc_pending;
        o_q_push      = 1'b0;
        o_q_data      = i_rx_byte;
        if (take) begin
            if (r_esc_pending) begin
                // flip bit 5 of the escaped byte
                o_q_data      = i_rx_byte ^ pfr_pkg::ESC_XOR;
                o_q_push      = 1'b1;
                n_esc_pending = 1'b0;
            end else if (i_rx_byte == pfr_pkg::ESC_BYTE) begin
                // drop the escape itself
                n_esc_pending = 1'b1;
            end else begin
                o_q_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pending <= 1'b0;
        end else begin
            r_esc_pending <= n_esc_pending;
        end
    end

endmodule

[hdl/pfr_parser.sv]
`timescale 1ns / 1ps

module pfr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_max_body_len,
    input  pfr_pkg::t_byte_req  i_req,
    output logic                o_pop,
    input  logic                i_out_full,
    output logic                o_out_push,
    output pfr_pkg::t_result    o_result
);

    typedef enum logic [3:0] {
        ST_HUNT, ST_ADDR, ST_CTRL, ST_PRO1, ST_PRO2, ST_CODE,
        ST_ID, ST_LEN1, ST_LEN2, ST_BODY, ST_FCS1, ST_FCS2
    } t_stage;

    localparam logic [15:0] FCS_INIT    = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD    = 16'hF0B8;
    localparam logic [15:0] FCS_POLY    = 16'h8408;
    localparam logic [7:0]  ADDR_BYTE   = 8'hFF;
    localparam logic [7:0]  CTRL_BYTE   = 8'h03;
    localparam logic [15:0] PID_LCP     = 16'h21C0;
    localparam logic [15:0] PID_PAP     = 16'h23C0;
    localparam logic [15:0] PID_CHAP    = 16'h23C2;
    localparam logic [15:0] HDR_LEN     = 16'd4;

    function automatic logic [15:0] fcs_byte(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] f;
        f = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
        end
        return f;
    endfunction

    t_stage      r_stage, n_stage;
    logic [15:0] r_fcs, n_fcs;
    logic [7:0]  r_first_half, n_first_half;
    logic [1:0]  r_proto, n_proto;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_length, n_length;
    logic [15:0] r_bytes_left, n_bytes_left;

    logic        take, emit, emit_kind;
    logic [1:0]  emit_status;
    logic [7:0]  b;
    logic [15:0] hdr_len, fcs_next, left_dec;

    assign take     = i_req.valid && !i_out_full;
    assign o_pop    = take;
    assign b        = i_req.data;
    assign hdr_len  = {r_first_half, b};
    assign fcs_next = fcs_byte(r_fcs, b);
    assign left_dec = (r_bytes_left != '0) ? r_bytes_left - 1'b1 : r_bytes_left;

    always_comb begin
        n_stage      = r_stage;
        n_fcs        = r_fcs;
        n_first_half = r_first_half;
        n_proto      = r_proto;
        n_code       = r_code;
        n_id         = r_id;
        n_length     = r_length;
        n_bytes_left = r_bytes_left;
        emit         = 1'b0;
        emit_kind    = pfr_pkg::KIND_STATUS;
        emit_status  = pfr_pkg::STAT_FCS_GOOD;
        if (take) begin
            if (r_stage == ST_HUNT) begin
                n_fcs = FCS_INIT;
                if (b == pfr_pkg::FLAG_BYTE) begin
                    n_stage = ST_ADDR;
                end
            end else begin
                n_fcs = fcs_next;
                unique case (r_stage)
                    ST_ADDR: begin
                        if (b == ADDR_BYTE) begin
                            n_stage = ST_CTRL;
                        end else if (b == pfr_pkg::FLAG_BYTE) begin
                            // another opening flag: restart the check
                            n_fcs = FCS_INIT;
                        end else begin
                            n_stage = ST_HUNT;
                        end
                    end
                    ST_CTRL: n_stage = (b == CTRL_BYTE) ? ST_PRO1 : ST_HUNT;
                    ST_PRO1: begin
                        n_first_half = b;
                        n_stage      = ST_PRO2;
                    end
                    ST_PRO2: begin
                        n_stage = ST_CODE;
                        if ({b, r_first_half} == PID_LCP) begin
                            n_proto = pfr_pkg::SEL_LCP;
                        end else if ({b, r_first_half} == PID_PAP) begin
                            n_proto = pfr_pkg::SEL_PAP;
                        end else if ({b, r_first_half} == PID_CHAP) begin
                            n_proto = pfr_pkg::SEL_CHAP;
                        end else begin
                            n_stage = ST_HUNT;
                        end
                    end
                    ST_CODE: begin
                        n_code  = b;
                        n_stage = ST_ID;
                    end
                    ST_ID: begin
                        n_id    = b;
                        n_stage = ST_LEN1;
                    end
                    ST_LEN1: begin
                        n_first_half = b;
                        n_stage      = ST_LEN2;
                    end
                    ST_LEN2: begin
                        if (hdr_len < HDR_LEN) begin
                            n_length    = '0;
                            n_stage     = ST_HUNT;
                            emit        = 1'b1;
                            emit_status = pfr_pkg::STAT_LEN_ERR;
                        end else begin
                            n_length = hdr_len - HDR_LEN;
                            if (n_length > i_max_body_len) begin
                                n_stage     = ST_HUNT;
                                emit        = 1'b1;
                                emit_status = pfr_pkg::STAT_LEN_ERR;
                            end else begin
                                n_bytes_left = n_length;
                                n_stage      = (n_length == '0) ? ST_FCS1 : ST_BODY;
                            end
                        end
                    end
                    ST_BODY: begin
                        n_bytes_left = left_dec;
                        if (left_dec == '0) begin
                            n_stage = ST_FCS1;
                        end
                        emit      = 1'b1;
                        emit_kind = pfr_pkg::KIND_DATA;
                    end
                    ST_FCS1: n_stage = ST_FCS2;
                    ST_FCS2: begin
                        n_stage     = ST_HUNT;
                        emit        = 1'b1;
                        emit_status = (fcs_next == FCS_GOOD) ? pfr_pkg::STAT_FCS_GOOD
                                                             : pfr_pkg::STAT_FCS_BAD;
                    end
                    default: n_stage = ST_HUNT;
                endcase
            end
        end
    end

    assign o_out_push            = emit;
    assign o_result.out_kind     = emit_kind;
    assign o_result.body_byte    = (emit_kind == pfr_pkg::KIND_DATA) ? b : 8'h00;
    assign o_result.protocol_sel = n_proto;
    assign o_result.msg_code     = n_code;
    assign o_result.msg_id       = n_id;
    assign o_result.body_len     = n_length;
    assign o_result.frame_status = emit_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= ST_HUNT;
            r_fcs        <= FCS_INIT;
            r_first_half <= '0;
            r_proto      <= pfr_pkg::SEL_LCP;
            r_code       <= '0;
            r_id         <= '0;
            r_length     <= '0;
            r_bytes_left <= '0;
        end else begin
            r_stage      <= n_stage;
            r_fcs        <= n_fcs;
            r_first_half <= n_first_half;
            r_proto      <= n_proto;
            r_code       <= n_code;
            r_id         <= n_id;
            r_length     <= n_length;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

[hdl/ppp_frame_receiver.sv]
`timescale 1ns / 1ps

// PPP receive framer with FCS-16 check.
// Input channel: raw line bytes on i_rx_byte; a request is taken at a clock edge
//   with push high and full low. 0x7D escapes are removed at the front.
// Result channel: while empty is low the oldest result sits on the o_* ports;
//   pop high at an edge takes it. A result is a body byte (o_out_kind 0) or an
//   end-of-frame status (o_out_kind 1) with the captured header fields.
// Throughput: one byte per cycle sustained while the result queue has room;
//   the parser does the FCS update and the parse step of a byte together.
// Path: a taken byte is written into the byte queue, parsed when it reaches
//   the head of that queue, and its result is written into the result queue.
// Stall: when the result queue fills, the parser holds; the byte queue then
//   fills and full rises. No request is lost.
// Configuration: APB write to byte address 0 sets max_body_len (reset 1500).
//   pready is tied high.
// Reset: synchronous, active low; clears both queues and the parse state and
//   sends the parser back to flag hunt.
module ppp_frame_receiver #(
    parameter int DEPTH = pfr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        empty,
    input  logic        pop,
    output logic        o_out_kind,
    output logic [7:0]  o_body_byte,
    output logic [1:0]  o_protocol_sel,
    output logic [7:0]  o_msg_code,
    output logic [7:0]  o_msg_id,
    output logic [15:0] o_body_len,
    output logic [1:0]  o_frame_status,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RES_W = $bits(pfr_pkg::t_result);

    logic [15:0]        r_max_body_len;
    logic               cfg_wr;

    logic               q_push, q_full, q_empty, q_pop;
    logic [7:0]         q_wdata, q_rdata;
    pfr_pkg::t_byte_req byte_req;

    logic               out_push, out_full;
    pfr_pkg::t_result   result_in, result_out;
    logic [RES_W-1:0]   result_bits;

    // Configuration register: word index taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == pfr_pkg::REG_MAX_BODY_LEN);
    assign prdata = (paddr[2] == pfr_pkg::REG_MAX_BODY_LEN) ? {16'h0000, r_max_body_len}
                                                           : 32'h0000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body_len <= pfr_pkg::MAX_BODY_RESET;
        end else if (cfg_wr) begin
            r_max_body_len <= pwdata[15:0];
        end
    end

    // Front: strip escapes, queue unescaped bytes
    pfr_unescape u_unescape (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    assign full = q_full;

    pfr_fifo #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_byte_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign byte_req.valid = !q_empty;
    assign byte_req.data  = q_rdata;

    // Back: header parse, FCS check, result generation
    pfr_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_body_len (r_max_body_len),
        .i_req          (byte_req),
        .o_pop          (q_pop),
        .i_out_full     (out_full),
        .o_out_push     (out_push),
        .o_result       (result_in)
    );

    // Result queue decouples the parser from the consumer
    pfr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (result_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (result_bits),
        .o_empty (empty)
    );

    assign result_out     = pfr_pkg::t_result'(result_bits);
    assign o_out_kind     = result_out.out_kind;
    assign o_body_byte    = result_out.body_byte;
    assign o_protocol_sel = result_out.protocol_sel;
    assign o_msg_code     = result_out.msg_code;
    assign o_msg_id       = result_out.msg_id;
    assign o_body_len     = result_out.body_len;
    assign o_frame_status = result_out.frame_status;

endmodule

[bench/ppp_frame_receiver_tb.sv]
`timescale 1ns / 1ps

// Bench for the PPP receive framer.
//
// Raw line bytes are built frame by frame into a queue, then fed to the block
// by a clocked driver. Each accepted request runs through a byte-level model
// of the framer kept here, which queues the results it should produce. A
// clocked monitor pops results and compares every field with the oldest one
// due. The run walks through several receive-unit settings, written over the
// configuration port only while nothing is in flight.
module ppp_frame_receiver_tb;

    localparam int          CLK_HALF      = 4;
    localparam int          RUN_LIMIT     = 300000;
    localparam int          SETTLE_CYCLES = 2 * pfr_pkg::QUEUE_DEPTH + 6;
    localparam int          LONG_HOLD     = 200;
    localparam int          PHASE_BYTES   = 110;
    localparam int          N_PHASES      = 6;

    // Wire order of the protocol field: first byte in the upper half
    localparam logic [15:0] LINE_LCP      = 16'hC021;
    localparam logic [15:0] LINE_PAP      = 16'hC023;
    localparam logic [15:0] LINE_CHAP     = 16'hC223;
    localparam logic [7:0]  ADDR_STATION  = 8'hFF;
    localparam logic [7:0]  CTRL_UI       = 8'h03;
    localparam logic [15:0] FCS_INIT      = 16'hFFFF;
    localparam logic [15:0] FCS_RESIDUE   = 16'hF0B8;
    localparam logic [15:0] FCS_POLY      = 16'h8408;
    localparam int          HDR_BYTES     = 4;

    // Register map: max_body_len at index 0, anything else is not decoded
    localparam logic [2:0]  MAX_LEN_ADDR  = {pfr_pkg::REG_MAX_BODY_LEN, 2'b00};
    localparam logic [2:0]  UNUSED_ADDR   = 3'b100;

    typedef enum logic [3:0] {
        S_HUNT, S_ADDR, S_CTRL, S_PROTO1, S_PROTO2, S_CODE, S_ID,
        S_LEN1, S_LEN2, S_BODY, S_FCS1, S_FCS2
    } t_parse_stage;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        empty;
    logic        pop       = 1'b0;
    logic        o_out_kind;
    logic [7:0]  o_body_byte;
    logic [1:0]  o_protocol_sel;
    logic [7:0]  o_msg_code;
    logic [7:0]  o_msg_id;
    logic [15:0] o_body_len;
    logic [1:0]  o_frame_status;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'b000;
    logic [31:0] pwdata    = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    ppp_frame_receiver i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_out_kind     (o_out_kind),
        .o_body_byte    (o_body_byte),
        .o_protocol_sel (o_protocol_sel),
        .o_msg_code     (o_msg_code),
        .o_msg_id       (o_msg_id),
        .o_body_len     (o_body_len),
        .o_frame_status (o_frame_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Line bytes waiting for the driver, and results the framer owes us
    logic [7:0]        line_bytes_q [$];
    pfr_pkg::t_result  results_due [$];
    int                line_bytes_queued = 0;
    int                fail_count = 0;
    int                cycle_count = 0;

    // Bench copy of the framer state and of the receive unit register
    logic [15:0]  max_len_cfg = pfr_pkg::MAX_BODY_RESET;
    t_parse_stage stage_m     = S_HUNT;
    logic         esc_armed   = 1'b0;
    logic [15:0]  fcs_acc     = FCS_INIT;
    logic [7:0]   held_byte   = 8'h00;
    logic [1:0]   proto_m     = pfr_pkg::SEL_LCP;
    logic [7:0]   code_m      = 8'h00;
    logic [7:0]   id_m        = 8'h00;
    logic [15:0]  len_m       = 16'h0;
    logic [15:0]  left_m      = 16'h0;

    // Idle knobs, long-hold handshake and per-side wait counters
    logic tx_idle_on  = 1'b0;
    logic rx_idle_on  = 1'b0;
    int   holds_asked = 0;
    int   holds_served = 0;
    int   hold_left   = 0;
    int   tx_wait     = 0;
    int   rx_wait     = 0;
    int   phase_max [N_PHASES];

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Byte-wise FCS-16, reflected polynomial
    function automatic logic [15:0] fcs16_next(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] f;
        f = fcs ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
        end
        return f;
    endfunction

    // Queue one result carrying the header fields captured so far
    function automatic void owe_result(input logic kind, input logic [7:0] data,
                                       input logic [1:0] status);
        pfr_pkg::t_result r;
        r.out_kind     = kind;
        r.body_byte    = data;
        r.protocol_sel = proto_m;
        r.msg_code     = code_m;
        r.msg_id       = id_m;
        r.body_len     = len_m;
        r.frame_status = status;
        results_due.push_back(r);
    endfunction

    // Advance the framer model by one accepted line byte
    function automatic void parse_line_byte(input logic [7:0] raw);
        logic [7:0]  b;
        logic [15:0] word;
        b = raw;
        // Strip escapes first: every later decision sees the unescaped byte
        if (esc_armed) begin
            b = raw ^ pfr_pkg::ESC_XOR;
            esc_armed = 1'b0;
        end else if (raw == pfr_pkg::ESC_BYTE) begin
            esc_armed = 1'b1;
            return;
        end
        if (stage_m == S_HUNT) begin
            fcs_acc = FCS_INIT;
            if (b == pfr_pkg::FLAG_BYTE) stage_m = S_ADDR;
            return;
        end
        fcs_acc = fcs16_next(fcs_acc, b);
        case (stage_m)
            S_ADDR: begin
                // Extra opening flags keep us waiting and restart the FCS
                if (b == ADDR_STATION) stage_m = S_CTRL;
                else if (b == pfr_pkg::FLAG_BYTE) fcs_acc = FCS_INIT;
                else stage_m = S_HUNT;
            end
            S_CTRL: stage_m = (b == CTRL_UI) ? S_PROTO1 : S_HUNT;
            S_PROTO1: begin
                held_byte = b;
                stage_m   = S_PROTO2;
            end
            S_PROTO2: begin
                word    = {held_byte, b};
                stage_m = S_CODE;
                if (word == LINE_LCP) proto_m = pfr_pkg::SEL_LCP;
                else if (word == LINE_PAP) proto_m = pfr_pkg::SEL_PAP;
                else if (word == LINE_CHAP) proto_m = pfr_pkg::SEL_CHAP;
                else stage_m = S_HUNT;
            end
            S_CODE: begin
                code_m  = b;
                stage_m = S_ID;
            end
            S_ID: begin
                id_m    = b;
                stage_m = S_LEN1;
            end
            S_LEN1: begin
                held_byte = b;
                stage_m   = S_LEN2;
            end
            S_LEN2: begin
                word = {held_byte, b};
                if (word < HDR_BYTES) begin
                    len_m   = 16'h0;
                    stage_m = S_HUNT;
                    owe_result(pfr_pkg::KIND_STATUS, 8'h00, pfr_pkg::STAT_LEN_ERR);
                end else begin
                    len_m = 16'(word - HDR_BYTES);
                    if (len_m > max_len_cfg) begin
                        stage_m = S_HUNT;
                        owe_result(pfr_pkg::KIND_STATUS, 8'h00, pfr_pkg::STAT_LEN_ERR);
                    end else begin
                        left_m  = len_m;
                        stage_m = (left_m == 16'h0) ? S_FCS1 : S_BODY;
                    end
                end
            end
            S_BODY: begin
                // Flags here are plain data: no abort inside a frame
                if (left_m != 16'h0) left_m = left_m - 16'h1;
                if (left_m == 16'h0) stage_m = S_FCS1;
                owe_result(pfr_pkg::KIND_DATA, b, pfr_pkg::STAT_FCS_GOOD);
            end
            S_FCS1: stage_m = S_FCS2;
            S_FCS2: begin
                stage_m = S_HUNT;
                owe_result(pfr_pkg::KIND_STATUS, 8'h00,
                           (fcs_acc == FCS_RESIDUE) ? pfr_pkg::STAT_FCS_GOOD
                                                    : pfr_pkg::STAT_FCS_BAD);
            end
            default: stage_m = S_HUNT;
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Match a popped result against the oldest one due
    function automatic void check_result();
        pfr_pkg::t_result want;
        if (results_due.size() == 0) begin
            $display("%0t: unexpected result, expected none actual kind %0d byte %h status %0d",
                     $time, o_out_kind, o_body_byte, o_frame_status);
            fail_count++;
            return;
        end
        want = results_due.pop_front();
        compare_field("out_kind", 16'(want.out_kind), 16'(o_out_kind));
        compare_field("body_byte", 16'(want.body_byte), 16'(o_body_byte));
        compare_field("protocol_sel", 16'(want.protocol_sel), 16'(o_protocol_sel));
        compare_field("msg_code", 16'(want.msg_code), 16'(o_msg_code));
        compare_field("msg_id", 16'(want.msg_id), 16'(o_msg_id));
        compare_field("body_len", want.body_len, o_body_len);
        compare_field("frame_status", 16'(want.frame_status), 16'(o_frame_status));
    endfunction

    // Driver: offer one line byte per request, hold it while full is high,
    // then wait the drawn number of idle cycles before the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push    <= 1'b0;
            tx_wait = 0;
        end else begin
            if (push && !full) parse_line_byte(i_rx_byte);
            if (!push || !full) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    push <= 1'b0;
                end else if (line_bytes_q.size() > 0) begin
                    i_rx_byte <= line_bytes_q.pop_front();
                    push      <= 1'b1;
                    tx_wait   = tx_idle_on ? $urandom_range(0, 3) : 0;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each popped result, then draw a stall before the next.
    // A long hold request from the stimulus blocks pop until its hold counter runs out.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop     <= 1'b0;
            rx_wait = 0;
        end else begin
            if (pop && !empty) begin
                check_result();
                rx_wait = rx_idle_on ? $urandom_range(0, 3) : 0;
            end
            if (holds_served != holds_asked) begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: timeout with %0d results still due", $time, results_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void push_line(input logic [7:0] b);
        line_bytes_q.push_back(b);
        line_bytes_queued++;
    endfunction

    // Send one unescaped byte, escaping it always when it is the escape code
    // and otherwise with the given percentage
    function automatic void put_line(input logic [7:0] b, input int esc_pct);
        if (b == pfr_pkg::ESC_BYTE || $urandom_range(0, 99) < esc_pct) begin
            push_line(pfr_pkg::ESC_BYTE);
            push_line(b ^ pfr_pkg::ESC_XOR);
        end else begin
            push_line(b);
        end
    endfunction

    // Body bytes lean toward the flag, the escape codes and the extremes
    function automatic logic [7:0] body_pick();
        case ($urandom_range(0, 11))
            0: return pfr_pkg::FLAG_BYTE;
            1: return pfr_pkg::ESC_BYTE;
            2: return pfr_pkg::ESC_BYTE ^ pfr_pkg::ESC_XOR;
            3: return 8'h00;
            4: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] proto_pick();
        case ($urandom_range(0, 2))
            0: return LINE_LCP;
            1: return LINE_PAP;
            default: return LINE_CHAP;
        endcase
    endfunction

    // Build one frame on the line. A header length that the framer rejects
    // ends the frame right after the length bytes.
    function automatic void queue_frame(input logic [15:0] proto_word, input logic [7:0] code,
                                        input logic [7:0] ident, input logic [15:0] hdr_len,
                                        input int n_flags, input bit bad_fcs,
                                        input int esc_pct);
        logic [7:0]  hdr [8];
        logic [15:0] fcs;
        logic [7:0]  b;
        repeat (n_flags) push_line(pfr_pkg::FLAG_BYTE);
        hdr = '{ADDR_STATION, CTRL_UI, proto_word[15:8], proto_word[7:0], code, ident,
                hdr_len[15:8], hdr_len[7:0]};
        fcs = FCS_INIT;
        for (int k = 0; k < 8; k++) begin
            fcs = fcs16_next(fcs, hdr[k]);
            put_line(hdr[k], esc_pct);
        end
        if (hdr_len < HDR_BYTES || hdr_len - HDR_BYTES > max_len_cfg) return;
        repeat (hdr_len - HDR_BYTES) begin
            b   = body_pick();
            fcs = fcs16_next(fcs, b);
            put_line(b, esc_pct);
        end
        fcs = ~fcs;
        if (bad_fcs) fcs = fcs ^ (16'h1 << $urandom_range(0, 15));
        put_line(fcs[7:0], esc_pct);
        put_line(fcs[15:8], esc_pct);
    endfunction

    // Lengths right at the receive unit limit and one past it
    function automatic void queue_limit_frames();
        if (max_len_cfg <= 16'd48)
            queue_frame(proto_pick(), 8'($urandom), 8'($urandom),
                        16'(max_len_cfg + HDR_BYTES), 1, 1'b0, 10);
        if (max_len_cfg <= 16'd65530)
            queue_frame(proto_pick(), 8'($urandom), 8'($urandom),
                        16'(max_len_cfg + HDR_BYTES + 1), 1, 1'b0, 10);
    endfunction

    // One random line sequence: mostly frames with random content, some with a
    // bad FCS, the rest length errors, broken headers and plain line noise
    function automatic void queue_random_frame();
        int          pick;
        int          n;
        logic [15:0] hdr_len;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            if (n > int'(max_len_cfg)) n = int'(max_len_cfg);
            queue_frame(proto_pick(), 8'($urandom), 8'($urandom), 16'(n + HDR_BYTES),
                        $urandom_range(1, 3), $urandom_range(0, 7) == 0,
                        10 * $urandom_range(0, 3));
        end else if (pick < 82) begin
            if (max_len_cfg > 16'd65530 || $urandom_range(0, 1) == 0)
                hdr_len = 16'($urandom_range(0, HDR_BYTES - 1));
            else
                hdr_len = 16'($urandom_range(max_len_cfg + HDR_BYTES + 1, 65535));
            queue_frame(proto_pick(), 8'($urandom), 8'($urandom), hdr_len,
                        $urandom_range(1, 2), 1'b0, 10);
        end else if (pick < 92) begin
            push_line(pfr_pkg::FLAG_BYTE);
            case ($urandom_range(0, 2))
                0: begin
                    b = 8'($urandom);
                    if (b == ADDR_STATION || b == pfr_pkg::FLAG_BYTE) b = 8'h00;
                    put_line(b, 0);
                end
                1: begin
                    put_line(ADDR_STATION, 0);
                    b = 8'($urandom);
                    if (b == CTRL_UI) b = 8'h13;
                    put_line(b, 0);
                end
                default: begin
                    put_line(ADDR_STATION, 0);
                    put_line(CTRL_UI, 0);
                    put_line(8'hC0, 0);
                    b = 8'($urandom);
                    if (b == LINE_LCP[7:0] || b == LINE_PAP[7:0]) b = 8'h57;
                    put_line(b, 0);
                end
            endcase
            repeat ($urandom_range(0, 6)) push_line(body_pick());
        end else begin
            repeat ($urandom_range(1, 8)) push_line(body_pick());
        end
    endfunction

    task automatic random_traffic(input int n_bytes);
        int goal;
        goal = line_bytes_queued + n_bytes;
        while (line_bytes_queued < goal) queue_random_frame();
    endtask

    // Hold the sender until every request is in and every result is out,
    // then let bytes that owe nothing clear the block
    task automatic wait_drained();
        while (line_bytes_q.size() != 0 || push || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == MAX_LEN_ADDR) max_len_cfg = data[15:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_max_len_reg();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MAX_LEN_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== max_len_cfg) begin
            $display("%0t: max_body_len readback mismatch, expected %h actual %h",
                     $time, max_len_cfg, prdata[15:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        phase_max = '{0, 5, 65531, 40, 1500, 0};
        phase_max[5] = $urandom_range(1, 300);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_max_len_reg();

        // Directed frames at the reset receive unit size
        queue_frame(LINE_LCP, 8'h01, 8'h00, 16'd4, 1, 1'b0, 0);      // empty body
        queue_frame(LINE_PAP, 8'hFF, 8'hFF, 16'd10, 3, 1'b0, 0);     // repeated flags
        queue_frame(LINE_CHAP, 8'h00, 8'h7E, 16'd8, 1, 1'b1, 100);   // all escaped, bad FCS
        push_line(pfr_pkg::FLAG_BYTE);                               // bad address
        push_line(8'h00);
        push_line(pfr_pkg::FLAG_BYTE);                               // bad control
        push_line(ADDR_STATION);
        push_line(8'h01);
        push_line(pfr_pkg::FLAG_BYTE);                               // unknown protocol
        push_line(ADDR_STATION);
        push_line(CTRL_UI);
        push_line(8'hC0);
        push_line(8'h57);
        queue_frame(LINE_LCP, 8'h09, 8'h7D, 16'd0, 1, 1'b0, 0);      // length under header
        queue_frame(LINE_PAP, 8'h80, 8'h01, 16'd3, 1, 1'b0, 0);
        queue_frame(LINE_CHAP, 8'h7F, 8'h80, 16'hFFFF, 1, 1'b0, 0);  // far above the limit
        push_line(pfr_pkg::ESC_BYTE);                                // escaped raw flag
        push_line(pfr_pkg::FLAG_BYTE);
        push_line(pfr_pkg::ESC_BYTE);                                // doubled escape
        push_line(pfr_pkg::ESC_BYTE);
        queue_frame(LINE_PAP, 8'h02, 8'h03, 16'd12, 2, 1'b0, 50);

        // Walk the receive unit through its settings, extremes included
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            apb_write(MAX_LEN_ADDR, {16'h0, 16'(phase_max[ph])});
            if (ph == 1) apb_write(UNUSED_ADDR, 32'h0000_0003);
            check_max_len_reg();
            // Set the idle knobs; in phase 3 also stall the receiver for a long stretch while requests keep coming
            tx_idle_on <= (ph != 3) ? ph[0] : 1'b0;
            rx_idle_on <= ph[1] | ph[2];
            if (ph == 3) begin
                holds_asked <= holds_asked + 1;
            end
            queue_limit_frames();
            random_traffic(PHASE_BYTES);
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
